### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the row interleave writer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/eprw_pkg.sv
// ---------------------------------------------------------------------------
// eprw_pkg
// types, opcodes and the output sequence table of the row interleave writer
// ---------------------------------------------------------------------------
package eprw_pkg;

    // fixed panel opcodes and data values
    localparam logic [7:0] OP_PANEL_SETTING  = 8'h00;
    localparam logic [7:0] PSET_VALUE        = 8'h0B;
    localparam logic [7:0] OP_PARTIAL_WINDOW = 8'h83;
    localparam logic [7:0] WIN_SCAN_VALUE    = 8'h01;
    localparam logic [7:0] ZERO_BYTE         = 8'h00;

    // register reset values
    localparam logic [9:0] WIDTH_RESET      = 10'd768;
    localparam logic [9:0] HEIGHT_RESET     = 10'd552;
    localparam logic [7:0] RES_OPCODE_RESET = 8'h61;
    localparam logic [7:0] DTM_OPCODE_RESET = 8'h10;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH      = 2'd0,
        CFG_HEIGHT     = 2'd1,
        CFG_RES_OPCODE = 2'd2,
        CFG_DTM_OPCODE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [9:0] width;
        logic [9:0] height;
        logic [7:0] res_opcode;
        logic [7:0] dtm_opcode;
    } t_cfg;

    // one classified input item
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       hdr;
        logic [9:0] prow;
    } t_item;

    // one bus result
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_command;
        logic       last;
    } t_result;

    // position in the output sequence of one item
    typedef enum logic [4:0] {
        ST_PSET_CMD  = 5'd0,
        ST_PSET_DATA = 5'd1,
        ST_RES_CMD   = 5'd2,
        ST_RES_WH    = 5'd3,
        ST_RES_WL    = 5'd4,
        ST_RES_HH    = 5'd5,
        ST_RES_HL    = 5'd6,
        ST_WIN_CMD   = 5'd7,
        ST_WIN_XSH   = 5'd8,
        ST_WIN_XSL   = 5'd9,
        ST_WIN_XEH   = 5'd10,
        ST_WIN_XEL   = 5'd11,
        ST_WIN_YSH   = 5'd12,
        ST_WIN_YSL   = 5'd13,
        ST_WIN_YEH   = 5'd14,
        ST_WIN_YEL   = 5'd15,
        ST_WIN_SCAN  = 5'd16,
        ST_DTM_CMD   = 5'd17,
        ST_DATA      = 5'd18
    } t_step;

    // bus byte and command flag for one sequence step
    function automatic t_result seq_result(t_step step, t_cfg cfg, logic [9:0] prow,
                                           logic [7:0] data);
        t_result    res;
        logic [9:0] wend;
        wend = (cfg.width == 10'd0) ? 10'd0 : cfg.width - 10'd1;
        res  = '{bus_byte: ZERO_BYTE, is_command: 1'b0, last: 1'b0};
        case (step)
            ST_PSET_CMD:  begin
                res.bus_byte   = OP_PANEL_SETTING;
                res.is_command = 1'b1;
            end
            ST_PSET_DATA: res.bus_byte = PSET_VALUE;
            ST_RES_CMD:   begin
                res.bus_byte   = cfg.res_opcode;
                res.is_command = 1'b1;
            end
            ST_RES_WH:    res.bus_byte = {6'd0, cfg.width[9:8]};
            ST_RES_WL:    res.bus_byte = cfg.width[7:0];
            ST_RES_HH:    res.bus_byte = {6'd0, cfg.height[9:8]};
            ST_RES_HL:    res.bus_byte = cfg.height[7:0];
            ST_WIN_CMD:   begin
                res.bus_byte   = OP_PARTIAL_WINDOW;
                res.is_command = 1'b1;
            end
            ST_WIN_XSH:   res.bus_byte = ZERO_BYTE;
            ST_WIN_XSL:   res.bus_byte = ZERO_BYTE;
            ST_WIN_XEH:   res.bus_byte = {6'd0, wend[9:8]};
            ST_WIN_XEL:   res.bus_byte = wend[7:0];
            ST_WIN_YSH:   res.bus_byte = {6'd0, prow[9:8]};
            ST_WIN_YSL:   res.bus_byte = prow[7:0];
            ST_WIN_YEH:   res.bus_byte = {6'd0, prow[9:8]};
            ST_WIN_YEL:   res.bus_byte = prow[7:0];
            ST_WIN_SCAN:  res.bus_byte = WIN_SCAN_VALUE;
            ST_DTM_CMD:   begin
                res.bus_byte   = cfg.dtm_opcode;
                res.is_command = 1'b1;
            end
            ST_DATA:      begin
                res.bus_byte = data;
                res.last     = 1'b1;
            end
            default:      res.bus_byte = ZERO_BYTE;
        endcase
        return res;
    endfunction

endpackage

### rtl/core/eprw_front.sv
// ---------------------------------------------------------------------------
// eprw_front
// accepts image bytes, tracks line position and row, maps the physical row
// ---------------------------------------------------------------------------
module eprw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  eprw_pkg::t_cfg i_cfg,
    input  logic           i_accept,
    input  logic [7:0]     i_data,
    input  logic           i_start,
    output eprw_pkg::t_item o_item
);
    import eprw_pkg::*;

    logic [7:0] r_bil;
    logic [9:0] r_row;
    logic [7:0] n_bil;
    logic [9:0] n_row;

    logic [7:0] line_len;
    logic [7:0] bil_eff;
    logic [9:0] row_base;
    logic [9:0] row_hdr;
    logic [8:0] half;
    logic [9:0] prow;
    logic [7:0] bil_inc;
    logic [9:0] row_inc;
    logic       hdr;
    logic       line_end;

    // classify the item and map its row
    always_comb begin
        line_len = (i_cfg.width[9:2] == 8'd0) ? 8'd1 : i_cfg.width[9:2];
        bil_eff  = i_start ? 8'd0 : r_bil;
        row_base = i_start ? 10'd0 : r_row;
        hdr      = (bil_eff == 8'd0);
        row_hdr  = (hdr && (row_base >= i_cfg.height)) ? 10'd0 : row_base;
        half     = i_cfg.height[9:1];
        if (i_cfg.height == 10'd0) begin
            prow = 10'd0;
        end else if (row_hdr < {1'b0, half}) begin
            prow = {row_hdr[8:0], 1'b0};
        end else begin
            prow = (i_cfg.height - 10'd1) - {row_hdr[8:0] - half, 1'b0};
        end
        bil_inc  = bil_eff + 8'd1;
        line_end = (bil_inc >= line_len) || (bil_inc == 8'd0);
        row_inc  = row_hdr + 10'd1;
        n_bil    = line_end ? 8'd0 : bil_inc;
        if (line_end) begin
            n_row = (row_inc >= i_cfg.height) ? 10'd0 : row_inc;
        end else begin
            n_row = row_hdr;
        end
        o_item = '{data: i_data, start: i_start, hdr: hdr, prow: prow};
    end

    // line position and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bil <= 8'd0;
            r_row <= 10'd0;
        end else if (i_accept) begin
            r_bil <= n_bil;
            r_row <= n_row;
        end
    end

endmodule

### rtl/core/eprw_queue.sv
// ---------------------------------------------------------------------------
// eprw_queue
// small register queue of classified items between front and back
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eprw_queue #(
    parameter int DEPTH = eprw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eprw_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output eprw_pkg::t_item o_head
);
    import eprw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

### rtl/core/eprw_back.sv
// ---------------------------------------------------------------------------
// eprw_back
// steps through init and window header bytes where an item needs them, then its data byte
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eprw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eprw_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  eprw_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tuser,
    output logic            o_m_tlast
);
    import eprw_pkg::*;

    logic    r_active;
    t_step   r_step;
    t_step   cur_step;
    t_step   n_step;
    t_result res;
    logic    out_free;
    logic    fire;

    // pick the current step and the one after it
    always_comb begin
        if (r_active) begin
            cur_step = r_step;
        end else if (i_head.start) begin
            cur_step = ST_PSET_CMD;
        end else if (i_head.hdr) begin
            cur_step = ST_WIN_CMD;
        end else begin
            cur_step = ST_DATA;
        end
        if ((cur_step == ST_RES_HL) && !i_head.hdr) begin
            n_step = ST_DATA;
        end else begin
            n_step = t_step'(5'(cur_step) + 5'd1);
        end
        res      = seq_result(cur_step, i_cfg, i_head.prow, i_head.data);
        out_free = !o_m_tvalid || i_m_tready;
        fire     = i_valid && out_free;
        o_pop    = fire && (cur_step == ST_DATA);
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_step     <= ST_DATA;
            o_m_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                r_active   <= (cur_step != ST_DATA);
                r_step     <= n_step;
                o_m_tvalid <= 1'b1;
                o_m_tdata  <= res.bus_byte;
                o_m_tuser  <= res.is_command;
                o_m_tlast  <= res.last;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_active_has_item, i_clk, i_rst_n, r_active |-> i_valid,
                "sequence in progress without a queued item")

endmodule

### rtl/core/epaper_row_interleave_writer_core.sv
// path: a byte accepted with an empty queue and free output register passes through the
//   queue and the output register of eprw_back to the master side, after any header bytes
// throughput: one plain image byte per cycle unless the bus stalls; the sequencer in
//   eprw_back sends a line's window header first, and for a start byte the init bytes too
// reset: synchronous active low; clears line position, row, queue and sequencer and
//   loads the register defaults; no clearing pass
// ---------------------------------------------------------------------------
// epaper_row_interleave_writer_core
// turns image bytes into panel bus bytes with init, window and data commands
// ---------------------------------------------------------------------------
module epaper_row_interleave_writer_core #(
    parameter int QUEUE_DEPTH = eprw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    // image byte input
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // [0] start_of_image
    // panel bus output
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] bus_byte
    output logic       o_m_tuser,   // [0] is_command
    output logic       o_m_tlast
);
    import eprw_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item head_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  s_accept;

    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && !q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width: WIDTH_RESET, height: HEIGHT_RESET,
                       res_opcode: RES_OPCODE_RESET, dtm_opcode: DTM_OPCODE_RESET};
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:      r_cfg.width      <= i_cfg_data;
                CFG_HEIGHT:     r_cfg.height     <= i_cfg_data;
                CFG_RES_OPCODE: r_cfg.res_opcode <= i_cfg_data[7:0];
                CFG_DTM_OPCODE: r_cfg.dtm_opcode <= i_cfg_data[7:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    eprw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (s_accept),
        .i_data   (i_s_tdata),
        .i_start  (i_s_tuser),
        .o_item   (front_item)
    );

    eprw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head_item)
    );

    eprw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (q_valid),
        .i_head     (head_item),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### tb/eprw_bus_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eprw_bus_checker
// follows every register write and image byte transfer, works out the panel
// bus bytes they must produce, and compares them in order with the master side
// ---------------------------------------------------------------------------
module eprw_bus_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port as seen by the block
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    // image byte side
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // [0] start_of_image
    // panel bus side
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] bus_byte
    input  logic       i_m_tuser,   // [0] is_command
    input  logic       i_m_tlast,
    // status for the testbench top
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results
);
    import eprw_pkg::*;

    // panel command codes and fixed values
    localparam logic [7:0] CMD_PANEL_SETTING   = 8'h00;
    localparam logic [7:0] PANEL_SETTING_VALUE = 8'h0B;
    localparam logic [7:0] CMD_PARTIAL_WINDOW  = 8'h83;
    localparam logic [7:0] WINDOW_SCAN_VALUE   = 8'h01;
    localparam logic [7:0] WINDOW_X_START      = 8'h00;

    // register values after reset
    localparam logic [9:0] DEFAULT_WIDTH  = 10'd768;
    localparam logic [9:0] DEFAULT_HEIGHT = 10'd552;
    localparam logic [7:0] DEFAULT_RES_OP = 8'h61;
    localparam logic [7:0] DEFAULT_DTM_OP = 8'h10;

    // shadow registers and line tracking
    logic [9:0] panel_width;
    logic [9:0] panel_height;
    logic [7:0] res_opcode;
    logic [7:0] dtm_opcode;
    logic [7:0] line_pos;
    logic [9:0] image_row;

    // bus bytes still owed by the block, oldest first
    t_result    expected_bus[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: bus transfer %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, o_results, field, got, want);
        o_fail_count++;
    endtask

    task automatic push_bus_byte(input logic [7:0] value, input logic is_cmd,
                                 input logic last);
        t_result res;
        res.bus_byte   = value;
        res.is_command = is_cmd;
        res.last       = last;
        expected_bus.push_back(res);
    endtask

    // bus bytes caused by one image byte, then line and row bookkeeping
    task automatic predict_bus_bytes(input logic [7:0] data, input logic sof);
        logic [7:0] line_len;
        logic [9:0] half;
        logic [9:0] wend;
        logic [9:0] prow;
        line_len = panel_width[9:2];
        if (line_len == 8'd0) begin
            line_len = 8'd1;
        end

        // init sequence: panel setting, then resolution
        if (sof) begin
            push_bus_byte(CMD_PANEL_SETTING, 1'b1, 1'b0);
            push_bus_byte(PANEL_SETTING_VALUE, 1'b0, 1'b0);
            push_bus_byte(res_opcode, 1'b1, 1'b0);
            push_bus_byte({6'd0, panel_width[9:8]}, 1'b0, 1'b0);
            push_bus_byte(panel_width[7:0], 1'b0, 1'b0);
            push_bus_byte({6'd0, panel_height[9:8]}, 1'b0, 1'b0);
            push_bus_byte(panel_height[7:0], 1'b0, 1'b0);
            line_pos  = 8'd0;
            image_row = 10'd0;
        end

        // line header: window over one interleaved physical row
        if (line_pos == 8'd0) begin
            if (image_row >= panel_height) begin
                image_row = 10'd0;
            end
            half = panel_height >> 1;
            wend = (panel_width == 10'd0) ? 10'd0 : panel_width - 10'd1;
            if (panel_height == 10'd0) begin
                prow = 10'd0;
            end else if (image_row < half) begin
                prow = image_row << 1;
            end else begin
                prow = panel_height - 10'd1 - ((image_row - half) << 1);
            end
            push_bus_byte(CMD_PARTIAL_WINDOW, 1'b1, 1'b0);
            push_bus_byte(WINDOW_X_START, 1'b0, 1'b0);
            push_bus_byte(WINDOW_X_START, 1'b0, 1'b0);
            push_bus_byte({6'd0, wend[9:8]}, 1'b0, 1'b0);
            push_bus_byte(wend[7:0], 1'b0, 1'b0);
            push_bus_byte({6'd0, prow[9:8]}, 1'b0, 1'b0);
            push_bus_byte(prow[7:0], 1'b0, 1'b0);
            push_bus_byte({6'd0, prow[9:8]}, 1'b0, 1'b0);
            push_bus_byte(prow[7:0], 1'b0, 1'b0);
            push_bus_byte(WINDOW_SCAN_VALUE, 1'b0, 1'b0);
            push_bus_byte(dtm_opcode, 1'b1, 1'b0);
        end

        // the image byte itself closes the run
        push_bus_byte(data, 1'b0, 1'b1);

        line_pos = line_pos + 8'd1;
        if (line_pos >= line_len || line_pos == 8'd0) begin
            line_pos  = 8'd0;
            image_row = image_row + 10'd1;
            if (image_row >= panel_height) begin
                image_row = 10'd0;
            end
        end
    endtask

    task automatic check_bus_byte();
        t_result want;
        o_results++;
        if (expected_bus.size() == 0) begin
            report_mismatch("transfer with nothing expected", int'(i_m_tdata), 0);
            return;
        end
        want = expected_bus.pop_front();
        if (i_m_tdata !== want.bus_byte) begin
            report_mismatch("bus_byte", int'(i_m_tdata), int'(want.bus_byte));
        end
        if (i_m_tuser !== want.is_command) begin
            report_mismatch("is_command", int'(i_m_tuser), int'(want.is_command));
        end
        if (i_m_tlast !== want.last) begin
            report_mismatch("last_of_run", int'(i_m_tlast), int'(want.last));
        end
    endtask

    // register writes, output check, then input prediction on each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            panel_width  = DEFAULT_WIDTH;
            panel_height = DEFAULT_HEIGHT;
            res_opcode   = DEFAULT_RES_OP;
            dtm_opcode   = DEFAULT_DTM_OP;
            line_pos     = 8'd0;
            image_row    = 10'd0;
            expected_bus.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_WIDTH:      panel_width  = i_cfg_data;
                    CFG_HEIGHT:     panel_height = i_cfg_data;
                    CFG_RES_OPCODE: res_opcode   = i_cfg_data[7:0];
                    CFG_DTM_OPCODE: dtm_opcode   = i_cfg_data[7:0];
                    default:        ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                check_bus_byte();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_bus_bytes(i_s_tdata, i_s_tuser);
            end
            o_pending <= expected_bus.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives image bytes and register settings into the row interleave writer
// with random gaps and stalls on both sides; the checker judges the bus
// ---------------------------------------------------------------------------
module tb_top;
    import eprw_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_LENGTH  = 150;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = CFG_WIDTH;
    logic [9:0] i_cfg_data  = 10'd0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'd0;    // [7:0] data_byte
    logic       i_s_tuser   = 1'b0;    // [0] start_of_image
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;             // [7:0] bus_byte
    logic       o_m_tuser;             // [0] is_command
    logic       o_m_tlast;

    int         fail_count;
    int         pending;
    int         results;
    int         items_sent     = 0;
    int         settings_used  = 0;
    int         hold_cycles    = 0;
    bit         send_quiet     = 1'b0;
    bit         recv_quiet     = 1'b0;

    epaper_row_interleave_writer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    eprw_bus_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    // one image byte transfer, then a random gap
    task automatic send_byte(input logic [7:0] data, input logic sof);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= sof;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
    endtask

    // block is idle once every owed bus byte has been taken
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // all four registers back to back
    task automatic load_settings(input logic [9:0] w, input logic [9:0] h,
                                 input logic [9:0] res_op, input logic [9:0] dtm_op);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_index <= CFG_RES_OPCODE;
        i_cfg_data  <= res_op;
        @(posedge i_clk);
        i_cfg_index <= CFG_DTM_OPCODE;
        i_cfg_data  <= dtm_op;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // bus receiver: random stalls, plus one long hold on request
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = recv_quiet ? 0 : $urandom_range(0, 17);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        int n;
        int phase;
        int cw;
        int ch;
        int res_op;
        int dtm_op;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: start byte, then plain bytes inside a long line
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        stop_sending();

        // two-byte lines, six rows: walk every row and wrap back to the top
        wait_idle();
        load_settings(10'd8, 10'd6, 10'h0FF, 10'h000);
        send_byte(8'h00, 1'b1);
        for (int k = 0; k < 12; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        stop_sending();

        // zero width and zero height, opcode bits above the register dropped
        wait_idle();
        load_settings(10'd0, 10'd0, 10'h3FF, 10'h0FF);
        for (int k = 0; k < 3; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        stop_sending();

        // width under four pixels and an odd height
        wait_idle();
        load_settings(10'd3, 10'd5, 10'h261, 10'h1A5);
        send_byte(8'hC3, 1'b1);
        for (int k = 0; k < 5; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        stop_sending();

        // random phases: each a fresh setting and a stream of short images
        phase = 0;
        n     = items_sent + RANDOM_ITEMS;
        while (items_sent < n) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       cw = $urandom_range(0, 3);
                1:       cw = 1023;
                2:       cw = $urandom_range(4, 1023);
                default: cw = $urandom_range(4, 48);
            endcase
            case ($urandom_range(0, 9))
                0:       ch = 0;
                1:       ch = 1023;
                2:       ch = $urandom_range(1, 1023);
                3:       ch = 2;
                default: ch = $urandom_range(1, 14);
            endcase
            case ($urandom_range(0, 7))
                0:       res_op = 0;
                1:       res_op = 255;
                default: res_op = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 7))
                0:       dtm_op = 255;
                1:       dtm_op = 0;
                default: dtm_op = $urandom_range(0, 1023);
            endcase
            load_settings(10'(cw), 10'(ch), 10'(res_op), 10'(dtm_op));
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            // one phase where the bus stops for a long time while bytes keep coming
            if (phase == 2) begin
                send_quiet  = 1'b1;
                hold_cycles = HOLD_LENGTH;
            end
            for (int k = $urandom_range(15, 45); k > 0; k--) begin
                send_byte(8'($urandom_range(0, 255)),
                          (phase == 2 || k % 17 == 0) ? ($urandom_range(0, 9) < 7)
                                                      : ($urandom_range(0, 29) == 0));
            end
            stop_sending();
            phase++;
        end

        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        wait_idle();
        repeat (40) @(posedge i_clk);

        $display("covered %0d image bytes over %0d register settings and one long bus hold",
                 items_sent, settings_used);
        $display("checked %0d bus transfers, %0d mismatches", results, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/eprw_pkg.sv
rtl/core/eprw_front.sv
rtl/core/eprw_queue.sv
rtl/core/eprw_back.sv
rtl/core/epaper_row_interleave_writer_core.sv
tb/eprw_bus_checker.sv
tb/tb_top.sv
